FILE: hdl/scsc_pkg.sv
// shared types, constants and helpers for the sbox chain stream cipher unit
// no dependencies; imported by every module of the block except scsc_sbox_ram
package scsc_pkg;

	localparam int BLOCK_BYTES_DEF = 32;
	localparam int KEY_BYTES       = 32;
	localparam int KEY_BITS        = 8 * KEY_BYTES;
	localparam int KEY_IDX_W       = $clog2(KEY_BYTES);
	localparam int APB_AW          = 6;
	localparam int APB_DW          = 64;
	localparam int REG_IDX_W       = 3;

	localparam logic [1:0] CMD_DATA    = 2'd0;
	localparam logic [1:0] CMD_SBOX    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY0 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY1 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY2 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KEY3 = 3'd4;

	typedef struct packed {
		logic                ctr_mode;
		logic [KEY_BITS-1:0] key;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic restart;
		logic ctr_mode;
		logic rotate;
	} eng_ctrl_t;

	typedef struct packed {
		logic busy;
	} eng_stat_t;

	function automatic logic [7:0] key_sel(input logic [KEY_BITS-1:0] k,
		input logic [KEY_IDX_W-1:0] i);
		return k[{i, 3'b000} +: 8];
	endfunction

endpackage

FILE: hdl/scsc_sbox_ram.sv
// 256 x 8 sbox memory, one write port and one registered read port
// depends on nothing
module scsc_sbox_ram (
	input  logic       clk,
	input  logic       we,
	input  logic [7:0] waddr,
	input  logic [7:0] wdata,
	input  logic [7:0] raddr,
	output logic [7:0] rdata_q
);

	logic [7:0] mem_q [256];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

FILE: hdl/scsc_cfg_regs.sv
// apb configuration registers: stream mode and four 64-bit key words
// depends on scsc_pkg
module scsc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scsc_pkg::APB_AW-1:0]   paddr,
	input  logic [scsc_pkg::APB_DW-1:0]   pwdata,
	output logic [scsc_pkg::APB_DW-1:0]   prdata,
	output scsc_pkg::cfg_t                cfg
);
	import scsc_pkg::*;

	logic                  mode_q;
	logic [3:0][63:0]      key_q;
	logic [REG_IDX_W-1:0]  idx;
	logic                  wr;

	assign idx = paddr[APB_AW-1:3];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			key_q  <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_MODE: mode_q   <= pwdata[0];
				REG_KEY0: key_q[0] <= pwdata;
				REG_KEY1: key_q[1] <= pwdata;
				REG_KEY2: key_q[2] <= pwdata;
				REG_KEY3: key_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE: prdata = {{(APB_DW-1){1'b0}}, mode_q};
			REG_KEY0: prdata = key_q[0];
			REG_KEY1: prdata = key_q[1];
			REG_KEY2: prdata = key_q[2];
			REG_KEY3: prdata = key_q[3];
			default:  prdata = '0;
		endcase
	end

	assign cfg.ctr_mode = mode_q;
	assign cfg.key      = key_q;

endmodule

FILE: hdl/scsc_block_engine.sv
// keystream block and counter shift registers with the byte-serial sbox chain sequencer
// depends on scsc_pkg; drives the read port of scsc_sbox_ram
module scsc_block_engine #(
	parameter int BLOCK_BYTES = scsc_pkg::BLOCK_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scsc_pkg::eng_ctrl_t           ctrl,
	input  logic [scsc_pkg::KEY_BITS-1:0] key,
	input  logic [7:0]                    sbox_rdata,
	output logic [7:0]                    sbox_raddr,
	output logic [7:0]                    head,
	output scsc_pkg::eng_stat_t           stat
);
	import scsc_pkg::*;

	localparam int CNT_W = $clog2(BLOCK_BYTES);

	localparam logic [2:0] E_IDLE = 3'd0;
	localparam logic [2:0] E_LOAD = 3'd1;
	localparam logic [2:0] E_FWD0 = 3'd2;
	localparam logic [2:0] E_FWD  = 3'd3;
	localparam logic [2:0] E_BWD0 = 3'd4;
	localparam logic [2:0] E_BWD  = 3'd5;
	localparam logic [2:0] E_CPY  = 3'd6;

	logic [BLOCK_BYTES-1:0][7:0] blk_q;
	logic [BLOCK_BYTES-1:0][7:0] ctr_q;
	logic [2:0]                  state_q;
	logic                        ph_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            kidx_q;
	logic [7:0]                  prev_q;
	logic                        restart_q;
	logic                        mode_q;
	logic                        inc_busy_q;
	logic [CNT_W-1:0]            inc_cnt_q;
	logic                        carry_q;
	logic [CNT_W-1:0]            ksel;
	logic [7:0]                  kb;

	always_comb begin
		unique case (state_q)
			E_FWD0:  ksel = '0;
			E_BWD0:  ksel = CNT_W'(BLOCK_BYTES - 1);
			default: ksel = kidx_q;
		endcase
	end

	assign kb = key_sel(key, KEY_IDX_W'(ksel));

	always_comb begin
		unique case (state_q)
			E_LOAD:  sbox_raddr = 8'(cnt_q);
			E_BWD:   sbox_raddr = blk_q[BLOCK_BYTES-1] + prev_q;
			default: sbox_raddr = prev_q + (blk_q[0] ^ kb);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= E_IDLE;
			ph_q       <= 1'b0;
			cnt_q      <= '0;
			kidx_q     <= '0;
			prev_q     <= '0;
			restart_q  <= 1'b0;
			mode_q     <= 1'b0;
			inc_busy_q <= 1'b0;
			inc_cnt_q  <= '0;
			carry_q    <= 1'b0;
			blk_q      <= '0;
			ctr_q      <= '0;
		end else begin
			// little-endian counter increment, one byte per cycle
			if (inc_busy_q) begin
				ctr_q     <= {ctr_q[0] + {7'b0, carry_q}, ctr_q[BLOCK_BYTES-1:1]};
				carry_q   <= carry_q && (ctr_q[0] == 8'hFF);
				inc_cnt_q <= inc_cnt_q + 1'b1;
				if (inc_cnt_q == CNT_W'(BLOCK_BYTES - 1)) begin
					inc_busy_q <= 1'b0;
				end
			end
			unique case (state_q)
				E_IDLE: begin
					if (ctrl.start) begin
						mode_q    <= ctrl.ctr_mode;
						restart_q <= ctrl.restart;
						cnt_q     <= '0;
						ph_q      <= 1'b0;
						if (ctrl.restart) begin
							state_q <= E_LOAD;
						end else begin
							state_q <= E_FWD0;
							if (ctrl.ctr_mode) begin
								blk_q      <= ctr_q;
								inc_busy_q <= 1'b1;
								inc_cnt_q  <= '0;
								carry_q    <= 1'b1;
							end
						end
					end else if (ctrl.rotate) begin
						blk_q <= {blk_q[0], blk_q[BLOCK_BYTES-1:1]};
					end
				end
				E_LOAD: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						blk_q <= {sbox_rdata, blk_q[BLOCK_BYTES-1:1]};
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(BLOCK_BYTES - 1)) begin
							state_q <= E_FWD0;
						end
					end
				end
				E_FWD0: begin
					blk_q   <= {blk_q[0] ^ kb, blk_q[BLOCK_BYTES-1:1]};
					prev_q  <= blk_q[0] ^ kb;
					kidx_q  <= CNT_W'(1);
					cnt_q   <= '0;
					ph_q    <= 1'b0;
					state_q <= E_FWD;
				end
				E_FWD: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						blk_q  <= {sbox_rdata, blk_q[BLOCK_BYTES-1:1]};
						prev_q <= sbox_rdata;
						kidx_q <= kidx_q + 1'b1;
						cnt_q  <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(BLOCK_BYTES - 2)) begin
							state_q <= E_BWD0;
						end
					end
				end
				E_BWD0: begin
					blk_q   <= {blk_q[BLOCK_BYTES-2:0], blk_q[BLOCK_BYTES-1] ^ kb};
					kidx_q  <= CNT_W'(BLOCK_BYTES - 2);
					cnt_q   <= '0;
					ph_q    <= 1'b0;
					state_q <= E_BWD;
				end
				E_BWD: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						blk_q  <= {blk_q[BLOCK_BYTES-2:0], sbox_rdata ^ kb};
						prev_q <= sbox_rdata;
						kidx_q <= kidx_q - 1'b1;
						cnt_q  <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(BLOCK_BYTES - 2)) begin
							state_q <= (restart_q && mode_q) ? E_CPY : E_IDLE;
						end
					end
				end
				E_CPY: begin
					// restart in counter mode: result seeds the counter
					ctr_q      <= blk_q;
					inc_busy_q <= 1'b1;
					inc_cnt_q  <= '0;
					carry_q    <= 1'b1;
					restart_q  <= 1'b0;
					state_q    <= E_FWD0;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign head      = blk_q[0];
	assign stat.busy = (state_q != E_IDLE) || inc_busy_q;

endmodule

FILE: hdl/sbox_chain_stream_cipher_unit.sv
// top level of the sbox chain stream cipher: word handshake, byte position, result register
// depends on scsc_pkg, scsc_cfg_regs, scsc_sbox_ram, scsc_block_engine
//
// Byte stream cipher: each data word (cmd 0) returns one word, data_byte XOR the next
// keystream byte, with the end marker copied; sbox writes and restarts return nothing.
// While the current block lasts, a data word goes from ST_IDLE to ST_OUT, where its result is
// registered. Every BLOCK_BYTES data words the next block is generated first, in ST_BUSY:
// the block and counter sit in byte shift registers and the forward and backward sbox chains
// make one serial lookup per byte through the registered sbox read port; in counter mode
// the counter increment runs alongside. A restart loads the block from the sbox, encrypts
// it, and in counter mode adds a copy state and one more block. An sbox write leaves the
// input ready. The sbox has no reset and no clearing pass; every entry that a restart or a
// block encryption reads must be written first. One accepted word is held while a finished
// result waits for out_ready.
module sbox_chain_stream_cipher_unit #(
	parameter int BLOCK_BYTES = scsc_pkg::BLOCK_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scsc_pkg::APB_AW-1:0] paddr,
	input  logic [scsc_pkg::APB_DW-1:0] pwdata,
	output logic [scsc_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic [7:0]                  data_byte,
	input  logic [7:0]                  sbox_index,
	input  logic [7:0]                  sbox_value,
	input  logic                        end_of_buffer,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        end_of_buffer_out
);
	import scsc_pkg::*;

	localparam int POS_W = $clog2(BLOCK_BYTES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	cfg_t             cfg;
	eng_ctrl_t        ectrl;
	eng_stat_t        estat;
	logic [7:0]       sbox_rdata;
	logic [7:0]       sbox_raddr;
	logic [7:0]       head;
	logic [1:0]       state_q;
	logic [POS_W-1:0] pos_q;
	logic             is_data_q;
	logic [7:0]       data_q;
	logic             eob_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             eob_out_q;
	logic             accept;
	logic             exhausted;
	logic             slot_free;
	logic             sbox_we;

	assign pready    = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign exhausted = (pos_q >= POS_W'(BLOCK_BYTES));
	assign slot_free = !out_valid_q || out_ready;
	assign sbox_we   = accept && (cmd == CMD_SBOX);

	always_comb begin
		ectrl.start    = 1'b0;
		ectrl.restart  = (cmd == CMD_RESTART);
		ectrl.ctr_mode = cfg.ctr_mode;
		ectrl.rotate   = (state_q == ST_OUT) && slot_free;
		if (accept) begin
			unique case (cmd)
				CMD_DATA:    ectrl.start = exhausted;
				CMD_RESTART: ectrl.start = 1'b1;
				default:     ectrl.start = 1'b0;
			endcase
		end
	end

	scsc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	scsc_sbox_ram u_sbox (
		.clk     (clk),
		.we      (sbox_we),
		.waddr   (sbox_index),
		.wdata   (sbox_value),
		.raddr   (sbox_raddr),
		.rdata_q (sbox_rdata)
	);

	scsc_block_engine #(
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ectrl),
		.key        (cfg.key),
		.sbox_rdata (sbox_rdata),
		.sbox_raddr (sbox_raddr),
		.head       (head),
		.stat       (estat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			is_data_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_DATA: begin
								is_data_q <= 1'b1;
								if (exhausted) begin
									pos_q   <= '0;
									state_q <= ST_BUSY;
								end else begin
									state_q <= ST_OUT;
								end
							end
							CMD_RESTART: begin
								is_data_q <= 1'b0;
								pos_q     <= '0;
								state_q   <= ST_BUSY;
							end
							default: ;
						endcase
					end
				end
				ST_BUSY: begin
					if (!estat.busy) begin
						state_q <= is_data_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						pos_q       <= pos_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_DATA)) begin
			data_q <= data_byte;
			eob_q  <= end_of_buffer;
		end
		if ((state_q == ST_OUT) && slot_free) begin
			out_byte_q <= data_q ^ head;
			eob_out_q  <= eob_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_byte          = out_byte_q;
	assign end_of_buffer_out = eob_out_q;

endmodule

FILE: hdl/scsc_checker.sv
// port-level checker for sbox_chain_stream_cipher_unit, with its bind
// depends on scsc_pkg and the top level's port names
module scsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] cmd,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       end_of_buffer_out
);
	import scsc_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(end_of_buffer_out))
		else $error("result word changed while stalled");

	// a data word blocks the input until its result is registered
	a_data_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_DATA) |=> !in_ready)
		else $error("input ready right after a data word");

	// sbox write does not stall the input
	a_sbox_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_SBOX) |=> in_ready)
		else $error("sbox write stalled the input");

	// a new result only appears while an accepted word is being finished
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word without a pending data word");

endmodule

bind sbox_chain_stream_cipher_unit scsc_checker u_scsc_checker (.*);
